// ----- rtl/ddao_pkg.sv -----
package ddao_pkg;

  // cordic depth, capped by the arctangent table
  localparam int CORDIC_ITERATIONS = 24;
  localparam int ATAN_ENTRIES      = 30;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;

  // field widths
  localparam int POS_W   = 48;
  localparam int HEAD_W  = 31;
  localparam int ANG_W   = 32;
  localparam int DELTA_W = 32;
  localparam int WB_W    = 32;

  // shared divider: 64-bit dividend, 61-bit divisor, one quotient bit a cycle
  localparam int DIV_W     = 64;
  localparam int DVS_W     = 61;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = 6;

  // angle constants, Q4.28
  localparam logic signed [ANG_W-1:0] PI_Q      = 32'sd843314856;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 32'sd421657428;
  localparam logic [30:0]             TWO_PI_Q  = 31'd1686629712;
  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 31'sd843314856;

  // reciprocal of the full turn, scaled by 2^62, for the heading wrap
  localparam logic [31:0] WRAP_RECIP = 32'((64'd1 << 62) / {33'd0, TWO_PI_Q});

  // cordic start value, Q2.29
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 32'sd326016437;

  localparam logic [WB_W-1:0] WB_RESET = 32'd19660800;

  typedef enum logic [1:0] {
    REQ_UPDATE,
    REQ_SET_X,
    REQ_SET_Y,
    REQ_ZERO_HEADING
  } req_t;

  // arctangent of 2^-i, Q4.28
  function automatic logic [27:0] atan_q28(input logic [4:0] idx);
    logic [27:0] v;
    unique case (idx)
      5'd0:    v = 28'd210828714;
      5'd1:    v = 28'd124459457;
      5'd2:    v = 28'd65760959;
      5'd3:    v = 28'd33381290;
      5'd4:    v = 28'd16755422;
      5'd5:    v = 28'd8385879;
      5'd6:    v = 28'd4193963;
      5'd7:    v = 28'd2097109;
      5'd8:    v = 28'd1048571;
      5'd9:    v = 28'd524287;
      5'd10:   v = 28'd262144;
      5'd11:   v = 28'd131072;
      5'd12:   v = 28'd65536;
      5'd13:   v = 28'd32768;
      5'd14:   v = 28'd16384;
      5'd15:   v = 28'd8192;
      5'd16:   v = 28'd4096;
      5'd17:   v = 28'd2048;
      5'd18:   v = 28'd1024;
      5'd19:   v = 28'd512;
      5'd20:   v = 28'd256;
      5'd21:   v = 28'd128;
      5'd22:   v = 28'd64;
      5'd23:   v = 28'd32;
      5'd24:   v = 28'd16;
      5'd25:   v = 28'd8;
      5'd26:   v = 28'd4;
      5'd27:   v = 28'd2;
      5'd28:   v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/differential_drive_arc_odometry.sv -----
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------------
// input    | in_valid / in_stall | in_req_type, in_left_delta, in_right_delta,
//          |                     | in_set_value
// result   | out_valid/out_stall | out_pos_x, out_pos_y, out_heading
// config   | cfg_wr_en           | cfg_wr_data (wheel base)
//
// set and zero-heading beats go from accept to ST_DONE, which loads the result register
// once no stalled result holds it. a straight update runs the heading-change divide, the
// 24 cordic steps, then the multiplies, pose update and result register.
// in an arc update the divider runs three times and the cordic twice, and the heading
// wrap is a reciprocal multiply and <= 2 subtracts.
// one beat in work at a time, the next taken while a result waits; rst_n is synchronous.
module differential_drive_arc_odometry import ddao_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic signed [DELTA_W-1:0] in_left_delta,
  input  logic signed [DELTA_W-1:0] in_right_delta,
  input  logic signed [POS_W-1:0]   in_set_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [POS_W-1:0]   out_pos_x,
  output logic signed [POS_W-1:0]   out_pos_y,
  output logic signed [HEAD_W-1:0]  out_heading,
  input  logic                      cfg_wr_en,
  input  logic [WB_W-1:0]           cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DTH,
    ST_DTH_END,
    ST_CORD0,
    ST_CORD0_END,
    ST_WRAP,
    ST_WRAP_MUL,
    ST_WRAP_FIX,
    ST_WRAP_END,
    ST_CORD1,
    ST_CORD1_END,
    ST_MUL,
    ST_ALOAD,
    ST_ADIV,
    ST_UPD,
    ST_DONE
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [WB_W-1:0]            wheel_base_r;
  logic signed [POS_W-1:0]    x_r, y_r;
  logic signed [ANG_W-1:0]    h_r, hn_r;
  logic signed [DELTA_W:0]    s_r;
  logic                       e_neg_r;
  logic [DVS_W-1:0]           dth_mag_r;
  logic                       straight_r, sel_r, u_neg_r, q_neg_r;
  logic signed [ANG_W-1:0]    s0_r, c0_r, s1_r, c1_r;
  logic signed [65:0]         prod_r;
  logic [DIV_W-1:0]           dq_r;
  logic [DVS_W-1:0]           drem_r, ddiv_r;
  logic [31:0]                wq_r;
  logic signed [ANG_W-1:0]    z_r, cx_r, cy_r;
  logic                       flip_r;
  logic                       out_valid_r;
  logic signed [POS_W-1:0]    out_x_r, out_y_r;
  logic signed [HEAD_W-1:0]   out_h_r;

  logic                       in_acc;
  logic signed [DELTA_W:0]    s_in, e_in;
  logic [DELTA_W:0]           e_mag;
  logic [WB_W-1:0]            wb_eff;

  // input decode
  assign in_acc = in_valid && (state_r == ST_IDLE);
  assign s_in   = (DELTA_W+1)'(in_left_delta) + (DELTA_W+1)'(in_right_delta);
  assign e_in   = (DELTA_W+1)'(in_right_delta) - (DELTA_W+1)'(in_left_delta);
  assign e_mag  = e_in[DELTA_W] ? (DELTA_W+1)'(-e_in) : (DELTA_W+1)'(e_in);
  assign wb_eff = (wheel_base_r == '0) ? WB_W'(1) : wheel_base_r;

  // shared restoring divider step
  logic [DVS_W:0]   div_trial, div_diff;
  logic             div_ge;
  logic [DVS_W-1:0] drem_nxt;
  logic [DIV_W-1:0] dq_nxt;

  assign div_trial = {drem_r, dq_r[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, ddiv_r};
  assign div_diff  = div_trial - {1'b0, ddiv_r};
  assign drem_nxt  = div_ge ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];
  assign dq_nxt    = {dq_r[DIV_W-2:0], div_ge};

  // shared cordic rotation step
  logic [4:0]              csh;
  logic signed [ANG_W-1:0] cx_sh, cy_sh, atan_v;
  logic signed [ANG_W-1:0] cx_nxt, cy_nxt, z_nxt;
  logic signed [ANG_W-1:0] cos_fin, sin_fin;

  assign csh    = cnt_r[4:0];
  assign cx_sh  = cx_r >>> csh;
  assign cy_sh  = cy_r >>> csh;
  assign atan_v = $signed({4'b0, atan_q28(csh)});

  always_comb begin
    if (!z_r[ANG_W-1]) begin
      cx_nxt = cx_r - cy_sh;
      cy_nxt = cy_r + cx_sh;
      z_nxt  = z_r - atan_v;
    end else begin
      cx_nxt = cx_r + cy_sh;
      cy_nxt = cy_r - cx_sh;
      z_nxt  = z_r + atan_v;
    end
  end

  assign cos_fin = flip_r ? -cx_r : cx_r;
  assign sin_fin = flip_r ? -cy_r : cy_r;

  // heading wrap: dividend and wrapped result
  logic signed [DVS_W:0]   dth_s;
  logic signed [62:0]      u_val, u_mag;
  logic [30:0]             wrap_rem, wrap_val;
  logic signed [ANG_W-1:0] hn_nxt;

  assign dth_s    = e_neg_r ? -$signed({1'b0, dth_mag_r}) : $signed({1'b0, dth_mag_r});
  assign u_val    = 63'(h_r) + 63'(dth_s) + 63'(PI_Q) - 63'sd1;
  assign u_mag    = u_val[62] ? -u_val : u_val;
  assign wrap_rem = drem_r[30:0];
  assign wrap_val = (u_neg_r && (wrap_rem != '0)) ? TWO_PI_Q - wrap_rem : wrap_rem;
  assign hn_nxt   = $signed({1'b0, wrap_val}) - PI_Q + 32'sd1;

  // wrap multiplier: quotient estimate from the upper bits, then quotient times turn
  logic [31:0] wmul_a, wmul_b;
  logic [63:0] wmul_p;

  assign wmul_a = (state_r == ST_WRAP) ? {1'b0, dq_r[60:30]} : wq_r;
  assign wmul_b = (state_r == ST_WRAP) ? WRAP_RECIP : {1'b0, TWO_PI_Q};
  assign wmul_p = wmul_a * wmul_b;

  // cordic preload: fold angles beyond a quarter turn
  logic signed [ANG_W-1:0] cord_ang, prep_z;
  logic                    prep_flip;

  assign cord_ang = (state_r == ST_WRAP_END) ? hn_nxt : h_r;

  always_comb begin
    priority if (cord_ang > HALF_PI_Q) begin
      prep_z    = cord_ang - PI_Q;
      prep_flip = 1'b1;
    end else if (cord_ang < -HALF_PI_Q) begin
      prep_z    = cord_ang + PI_Q;
      prep_flip = 1'b1;
    end else begin
      prep_z    = cord_ang;
      prep_flip = 1'b0;
    end
  end

  // shared multiplier
  logic signed [ANG_W:0] mul_b;
  logic signed [65:0]    mul_p;
  logic [DIV_W-1:0]      prod_mag;

  always_comb begin
    if (straight_r) begin
      mul_b = sel_r ? (ANG_W+1)'(s0_r) : (ANG_W+1)'(c0_r);
    end else begin
      mul_b = sel_r ? (ANG_W+1)'(c0_r) - (ANG_W+1)'(c1_r)
                    : (ANG_W+1)'(s1_r) - (ANG_W+1)'(s0_r);
    end
  end

  assign mul_p    = s_r * mul_b;
  assign prod_mag = prod_r[65] ? DIV_W'(-prod_r) : DIV_W'(prod_r);

  // position update with saturation
  logic [DIV_W-1:0]        upd_mag;
  logic                    upd_neg;
  logic signed [POS_W-1:0] pos_old, pos_new;
  logic signed [64:0]      upd_delta, pos_sum;

  assign upd_mag   = straight_r ? {30'b0, prod_mag[DIV_W-1:30]} : {2'b0, dq_r[DIV_W-1:2]};
  assign upd_neg   = straight_r ? prod_r[65] : q_neg_r;
  assign pos_old   = sel_r ? y_r : x_r;
  assign upd_delta = upd_neg ? -$signed({1'b0, upd_mag}) : $signed({1'b0, upd_mag});
  assign pos_sum   = 65'(pos_old) + upd_delta;

  always_comb begin
    if ((&pos_sum[64:POS_W-1]) || !(|pos_sum[64:POS_W-1])) begin
      pos_new = pos_sum[POS_W-1:0];
    end else if (pos_sum[64]) begin
      pos_new = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_new = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // sequencer, pose and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      wheel_base_r <= WB_RESET;
      x_r          <= '0;
      y_r          <= '0;
      h_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wheel_base_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= (req_t'(in_req_type) == REQ_UPDATE) ? ST_DTH : ST_DONE;
            unique case (req_t'(in_req_type))
              REQ_UPDATE: begin
                s_r     <= s_in;
                e_neg_r <= e_in[DELTA_W];
                dq_r    <= {3'b0, e_mag, 28'b0};
                drem_r  <= '0;
                ddiv_r  <= {29'b0, wb_eff};
                cnt_r   <= '0;
              end
              REQ_SET_X:        x_r <= in_set_value;
              REQ_SET_Y:        y_r <= in_set_value;
              REQ_ZERO_HEADING: h_r <= '0;
            endcase
          end
        end

        ST_DTH, ST_ADIV: begin
          dq_r   <= dq_nxt;
          drem_r <= drem_nxt;
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            priority case (state_r)
              ST_DTH:  state_r <= ST_DTH_END;
              default: state_r <= ST_UPD;
            endcase
          end
        end

        ST_DTH_END: begin
          dth_mag_r  <= dq_r[DVS_W-1:0];
          straight_r <= (dq_r == '0);
          sel_r      <= 1'b0;
          z_r        <= prep_z;
          flip_r     <= prep_flip;
          cx_r       <= CORDIC_GAIN;
          cy_r       <= '0;
          cnt_r      <= '0;
          state_r    <= ST_CORD0;
        end

        ST_CORD0, ST_CORD1: begin
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
            state_r <= (state_r == ST_CORD0) ? ST_CORD0_END : ST_CORD1_END;
          end
        end

        ST_CORD0_END: begin
          c0_r <= cos_fin;
          s0_r <= sin_fin;
          if (straight_r) begin
            state_r <= ST_MUL;
          end else begin
            u_neg_r <= u_val[62];
            dq_r    <= {1'b0, u_mag};
            state_r <= ST_WRAP;
          end
        end

        // quotient estimate, at most two below the true quotient
        ST_WRAP: begin
          wq_r    <= wmul_p[63:32];
          state_r <= ST_WRAP_MUL;
        end

        ST_WRAP_MUL: begin
          drem_r  <= DVS_W'(dq_r - wmul_p);
          state_r <= ST_WRAP_FIX;
        end

        // bring the remainder below one turn
        ST_WRAP_FIX: begin
          if (drem_r >= {30'b0, TWO_PI_Q}) begin
            drem_r <= drem_r - {30'b0, TWO_PI_Q};
          end else begin
            state_r <= ST_WRAP_END;
          end
        end

        ST_WRAP_END: begin
          hn_r    <= hn_nxt;
          z_r     <= prep_z;
          flip_r  <= prep_flip;
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          cnt_r   <= '0;
          state_r <= ST_CORD1;
        end

        ST_CORD1_END: begin
          c1_r    <= cos_fin;
          s1_r    <= sin_fin;
          state_r <= ST_MUL;
        end

        ST_MUL: begin
          prod_r  <= mul_p;
          state_r <= straight_r ? ST_UPD : ST_ALOAD;
        end

        ST_ALOAD: begin
          q_neg_r <= prod_r[65] ^ e_neg_r;
          dq_r    <= prod_mag;
          drem_r  <= '0;
          ddiv_r  <= dth_mag_r;
          cnt_r   <= '0;
          state_r <= ST_ADIV;
        end

        ST_UPD: begin
          if (sel_r) begin
            y_r <= pos_new;
            if (!straight_r) begin
              h_r <= hn_r;
            end
            state_r <= ST_DONE;
          end else begin
            x_r     <= pos_new;
            sel_r   <= 1'b1;
            state_r <= ST_MUL;
          end
        end

        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_h_r     <= h_r[HEAD_W-1:0];
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_heading = out_h_r;

endmodule

// ----- rtl/ddao_checker.sv -----
module ddao_checker import ddao_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                in_req_type,
  input logic signed [DELTA_W-1:0] in_left_delta,
  input logic signed [DELTA_W-1:0] in_right_delta,
  input logic signed [POS_W-1:0]   in_set_value,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [POS_W-1:0]   out_pos_x,
  input logic signed [POS_W-1:0]   out_pos_y,
  input logic signed [HEAD_W-1:0]  out_heading,
  input logic                      cfg_wr_en,
  input logic [WB_W-1:0]           cfg_wr_data
);

  // one beat in flight: the input closes right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a beat is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) &&
                               $stable(out_pos_y) && $stable(out_heading))
    else $error("stalled result changed");

  // reported heading stays in the half-open turn
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading <= HEAD_MAX) && (out_heading > -HEAD_MAX))
    else $error("heading out of range");

  // set x reaches the result output when the result side is free
  a_set_x: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_SET_X) && !out_valid
      |-> ##2 (out_valid && (out_pos_x == $past(in_set_value, 2))))
    else $error("set x result wrong");

endmodule

bind differential_drive_arc_odometry ddao_checker u_ddao_checker (.*);

// ----- sim/tb_top.sv -----
module tb_top;
  import ddao_pkg::*;

  localparam longint POSE_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POSE_MIN   = -POSE_MAX - 1;
  localparam longint PI_FX      = 843314856;
  localparam longint HALF_PI_FX = 421657428;
  localparam longint START_GAIN = 326016437;
  localparam int     DRAIN_CYC  = 400;
  localparam int     CYCLE_LIMIT = 3000000;

  // idle mode per phase
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  typedef struct {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [HEAD_W-1:0] h;
  } pose_t;

  // pose tracker and expected-pose queue
  class pose_scoreboard;
    longint pos_x, pos_y, head;
    bit [WB_W-1:0] wheel_base;
    pose_t pending[$];
    int errors, matched;
    longint atan_tab[30] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

    function new();
      pos_x = 0; pos_y = 0; head = 0; wheel_base = WB_RESET;
      errors = 0; matched = 0;
    endfunction

    function longint clamp_pos(longint v);
      if (v > POSE_MAX) return POSE_MAX;
      if (v < POSE_MIN) return POSE_MIN;
      return v;
    endfunction

    // rotation cordic with half-turn folding, Q4.28 in, Q2.29 out
    function void rotate(longint a, output longint sn, output longint cs);
      bit flip;
      longint cx, cy, z, tx;
      flip = 0; cx = START_GAIN; cy = 0;
      if (a > HALF_PI_FX) begin
        a -= PI_FX; flip = 1;
      end else if (a < -HALF_PI_FX) begin
        a += PI_FX; flip = 1;
      end
      z = a;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        tx = cx;
        if (z >= 0) begin
          cx = cx - (cy >>> i); cy = cy + (tx >>> i); z -= atan_tab[i];
        end else begin
          cx = cx + (cy >>> i); cy = cy - (tx >>> i); z += atan_tab[i];
        end
      end
      cs = flip ? -cx : cx;
      sn = flip ? -cy : cy;
    endfunction

    function longint wrap_angle(longint a);
      longint r;
      r = (a + PI_FX - 1) % (2 * PI_FX);
      if (r < 0) r += 2 * PI_FX;
      return r - PI_FX + 1;
    endfunction

    function void odometry(longint l, longint r);
      longint s, e, wb, dth, s0, c0, s1, c1, hn;
      s = l + r; e = r - l;
      wb = (wheel_base == 0) ? 1 : longint'({32'd0, wheel_base});
      dth = (e * (longint'(1) << 28)) / wb;
      rotate(head, s0, c0);
      if (dth == 0) begin
        pos_x = clamp_pos(pos_x + (s * c0) / (longint'(1) << 30));
        pos_y = clamp_pos(pos_y + (s * s0) / (longint'(1) << 30));
      end else begin
        hn = wrap_angle(head + dth);
        rotate(hn, s1, c1);
        pos_x = clamp_pos(pos_x + ((s * (s1 - s0)) / dth) / 4);
        pos_y = clamp_pos(pos_y + ((s * (c0 - c1)) / dth) / 4);
        head = hn;
      end
    endfunction

    // accepted request beat: advance pose and queue the expected result
    function void note_request(req_t req, logic signed [31:0] l, logic signed [31:0] r,
                               logic signed [POS_W-1:0] sv);
      pose_t p;
      case (req)
        REQ_UPDATE:       odometry(longint'(l), longint'(r));
        REQ_SET_X:        pos_x = longint'(sv);
        REQ_SET_Y:        pos_y = longint'(sv);
        REQ_ZERO_HEADING: head = 0;
      endcase
      p.x = pos_x[POS_W-1:0]; p.y = pos_y[POS_W-1:0]; p.h = head[HEAD_W-1:0];
      pending.push_back(p);
    endfunction

    // accepted result beat
    function void check_pose(pose_t got);
      pose_t exp_p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d h=%0d", $time, got.x, got.y, got.h);
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      if (got.x !== exp_p.x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, exp_p.x, got.x); errors++;
      end
      if (got.y !== exp_p.y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, exp_p.y, got.y); errors++;
      end
      if (got.h !== exp_p.h) begin
        $display("%0t: heading expected %0d actual %0d", $time, exp_p.h, got.h); errors++;
      end
      matched++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_wr_en;
  logic [1:0] in_req_type;
  logic signed [DELTA_W-1:0] in_left_delta, in_right_delta;
  logic signed [POS_W-1:0] in_set_value, out_pos_x, out_pos_y;
  logic signed [HEAD_W-1:0] out_heading;
  logic [WB_W-1:0] cfg_wr_data;

  pose_scoreboard sb = new();
  idle_t idle_mode = IDLE_NONE;
  int cycles = 0;
  int n_req[4] = '{0, 0, 0, 0};
  int n_cfg = 0;

  differential_drive_arc_odometry uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_left_delta(in_left_delta), .in_right_delta(in_right_delta),
    .in_set_value(in_set_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check beats, random stall
  always @(posedge clk) begin
    pose_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_pos_x; got.y = out_pos_y; got.h = out_heading;
      sb.check_pose(got);
    end
    if (idle_mode == IDLE_RECV) out_stall <= ($urandom_range(99) < 49);
    else if (idle_mode == IDLE_BOTH) out_stall <= ($urandom_range(99) < 27);
    else out_stall <= 1'b0;
  end

  // one request beat, with optional sender gaps
  task automatic send_req(req_t req, logic signed [31:0] l, logic signed [31:0] r,
                          logic signed [POS_W-1:0] sv);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 49 : (idle_mode == IDLE_BOTH) ? 27 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req; in_left_delta <= l; in_right_delta <= r; in_set_value <= sv;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, l, r, sv);
    n_req[req]++;
  endtask

  // wheel base write once the pipe has drained
  task automatic write_wheel_base(logic [WB_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.wheel_base = v;
    n_cfg++;
  endtask

  // random request, mostly modest wheel travel
  task automatic random_req();
    req_t req;
    logic signed [31:0] l, r;
    logic signed [POS_W-1:0] sv;
    int k;
    k = $urandom_range(99);
    req = (k < 70) ? REQ_UPDATE : (k < 80) ? REQ_SET_X : (k < 90) ? REQ_SET_Y
                                                                  : REQ_ZERO_HEADING;
    if ($urandom_range(99) < 80) begin
      l = $signed($urandom_range(0, 26214400)) - 13107200;
      r = ($urandom_range(3) == 0) ? l : l + $signed($urandom_range(0, 2621440)) - 1310720;
    end else begin
      l = $urandom; r = $urandom;
    end
    if ($urandom_range(99) < 50) sv = POS_W'({$urandom, $urandom});
    else sv = POS_W'($signed($urandom_range(0, 200000000)) - 100000000);
    send_req(req, l, r, sv);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; cfg_wr_en = 1'b0;
    in_req_type = REQ_UPDATE; in_left_delta = '0; in_right_delta = '0;
    in_set_value = '0; cfg_wr_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero move, straight, arcs, saturation, set and clear
    send_req(REQ_UPDATE, 0, 0, 0);
    send_req(REQ_UPDATE, 32'sd65536000, 32'sd65536000, 0);
    send_req(REQ_UPDATE, 32'sd655360, 32'sd3276800, 48'sh1234);
    send_req(REQ_UPDATE, 32'sd3276800, -32'sd655360, 0);
    send_req(REQ_SET_X, 32'h7FFFFFFF, 32'h80000000, 48'sh7FFF_FFFF_FFFF);
    send_req(REQ_ZERO_HEADING, 32'h80000000, 32'h7FFFFFFF, 48'sh8000_0000_0000);
    send_req(REQ_UPDATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    send_req(REQ_SET_X, 0, 0, 48'sh8000_0000_0000);
    send_req(REQ_UPDATE, 32'sh80000000, 32'sh80000000, 0);
    send_req(REQ_SET_Y, 0, 0, 48'sh7FFF_FFFF_FFFF);
    send_req(REQ_UPDATE, 32'sh80000000, 32'sh7FFFFFFF, 0);
    send_req(REQ_UPDATE, 32'sh7FFFFFFF, 32'sh80000000, 0);
    send_req(REQ_SET_Y, 0, 0, 48'sh8000_0000_0000);
    send_req(REQ_ZERO_HEADING, 0, 0, 0);
    write_wheel_base(32'hFFFFFFFF);
    send_req(REQ_UPDATE, 32'sd1000, 32'sd1001, 0);
    send_req(REQ_UPDATE, 32'sd0, 32'sd65536000, 0);
    write_wheel_base(32'd0);
    send_req(REQ_UPDATE, 32'sd7, 32'sd12, 0);
    send_req(REQ_UPDATE, 32'sh80000000, 32'sh7FFFFFFF, 0);
    write_wheel_base(32'd65536);
    send_req(REQ_UPDATE, 32'sd65536, 32'sd262144, 0);
    send_req(REQ_UPDATE, -32'sd131072, 32'sd131072, 0);

    // random phases, each with its own wheel base and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_wheel_base(WB_RESET);
        1: write_wheel_base(32'd65536);
        2: write_wheel_base(32'hFFFFFFFF);
        default: write_wheel_base($urandom_range(32'hFFFFFFFF, 32'd65536));
      endcase
      idle_mode = idle_t'(ph);
      for (int i = 0; i < 200; i++) random_req();
    end

    // drain
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d updates, %0d set-x, %0d set-y, %0d zero-heading beats",
             n_req[0], n_req[1], n_req[2], n_req[3]);
    $display("%0d results checked over %0d wheel base settings", sb.matched, n_cfg + 1);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
